// ===== rtl/lfu_pkg.sv =====
// lfu_pkg: sizes, codes, word types and width helpers shared by the
// lfu register map table modules; depends on nothing
package lfu_pkg;

    // table geometry
    localparam int NUM_SLOTS   = 16;
    localparam int GUEST_BITS  = 7;
    localparam int USE_BITS    = 16;
    localparam int SLOT_BITS   = $clog2(NUM_SLOTS);

    // port field widths
    localparam int REQ_W       = 2;
    localparam int GUEST_W     = 7;
    localparam int HOST_W      = 4;
    localparam int KIND_W      = 3;
    localparam int MASK_BITS   = 16;

    // victim search groups, minimum taken per group then across groups
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = (NUM_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [MASK_BITS-1:0] RESERVED_RESET = 16'd499;

    typedef enum logic [REQ_W-1:0] {
        REQ_MAP    = 2'd0,
        REQ_WB_ALL = 2'd1,
        REQ_INVAL  = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT   = 3'd0,
        KIND_FREE  = 3'd1,
        KIND_EVICT = 3'd2,
        KIND_STORE = 3'd3,
        KIND_DONE  = 3'd4,
        KIND_NONE  = 3'd5
    } kind_t;

    // input word
    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [GUEST_W-1:0] guest_reg;
        logic               is_dest;
        logic [HOST_W-1:0]  host_index;
    } lfu_in_t;

    // result word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [HOST_W-1:0]  host_slot;
        logic [GUEST_W-1:0] guest_out;
        logic [GUEST_W-1:0] evicted_guest;
        logic               load_needed;
        logic               last;
    } lfu_out_t;

    // decoded command between front and back
    typedef struct packed {
        req_t                  req;
        logic [GUEST_BITS-1:0] guest;
        logic                  load;
        logic                  inv_ok;
        logic [SLOT_BITS-1:0]  slot;
    } cmd_t;

    function automatic logic [GUEST_BITS-1:0] guest_from_port(input logic [GUEST_W-1:0] g);
        logic [GUEST_BITS+GUEST_W-1:0] w;
        w = {{GUEST_BITS{1'b0}}, g};
        return w[GUEST_BITS-1:0];
    endfunction

    function automatic logic [GUEST_W-1:0] guest_to_port(input logic [GUEST_BITS-1:0] g);
        logic [GUEST_BITS+GUEST_W-1:0] w;
        w = {{GUEST_W{1'b0}}, g};
        return w[GUEST_W-1:0];
    endfunction

    function automatic logic [SLOT_BITS-1:0] slot_from_port(input logic [HOST_W-1:0] s);
        logic [SLOT_BITS+HOST_W-1:0] w;
        w = {{SLOT_BITS{1'b0}}, s};
        return w[SLOT_BITS-1:0];
    endfunction

    function automatic logic [HOST_W-1:0] slot_to_port(input logic [SLOT_BITS-1:0] s);
        logic [SLOT_BITS+HOST_W-1:0] w;
        w = {{HOST_W{1'b0}}, s};
        return w[HOST_W-1:0];
    endfunction

endpackage

// ===== rtl/lfu_register_map_table.sv =====
// lfu_register_map_table: top level, holds the reserved slot mask and joins
// the request front, the table engine and the result queue; depends on lfu_pkg
//
// Usage:
//   Requests enter as words on item with push/full; a word is taken when push
//   is high and full is low. Results leave as words on result with
//   empty/pop; the oldest result is shown while empty is low and is taken
//   when pop is high. Every request ends with one word that has last set.
//   cfg_we/cfg_wdata write the reserved slot mask; write it only while idle.
//   A map request passes through the engine as table compare and group
//   minimum when the engine takes the command, then final victim pick and
//   table update. Write-back-all takes the command, then gives one store word
//   per mapped slot and the done word; invalidate gives a store word if the
//   slot is mapped and then the done word, clear only the done word.
//   A two-entry command queue lets requests be taken while the engine works;
//   a two-entry result queue lets the engine finish a word while the
//   receiver stalls. When the result queue is full the engine holds and the
//   command queue fills, then full goes high.
//   Reset empties the table and both queues and loads the mask with 499.
module lfu_register_map_table import lfu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  lfu_in_t              item,
    output logic                 empty,
    input  logic                 pop,
    output lfu_out_t             result,
    input  logic                 cfg_we,
    input  logic [MASK_BITS-1:0] cfg_wdata
);

    logic [MASK_BITS-1:0] reserved_mask_reg;
    logic [MASK_BITS-1:0] reserved_mask_next;
    logic                 cmd_valid;
    cmd_t                 cmd;
    logic                 cmd_pop;
    logic                 res_full;
    logic                 res_push;
    lfu_out_t             res;

    // reserved slot mask register
    assign reserved_mask_next = cfg_we ? cfg_wdata : reserved_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_mask_reg <= RESERVED_RESET;
        end
        else
        begin
            reserved_mask_reg <= reserved_mask_next;
        end
    end

    // request decode and command queue
    lfu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // table engine
    lfu_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .reserved_mask (reserved_mask_reg),
        .res_full      (res_full),
        .res_push      (res_push),
        .res           (res)
    );

    // result queue
    lfu_out_queue u_out_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res),
        .empty (empty),
        .pop   (pop),
        .rdata (result)
    );

endmodule

// ===== rtl/lfu_front.sv =====
// lfu_front: accepts request words, decodes them into commands and holds
// them in a two-entry command queue; depends on lfu_pkg
module lfu_front import lfu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  lfu_in_t item,
    output logic    cmd_valid,
    output cmd_t    cmd,
    input  logic    cmd_pop
);

    localparam int QDEPTH = 2;

    cmd_t       cmd_q_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    cmd_t       new_cmd;
    logic       do_push;

    // classify the incoming request
    always_comb
    begin
        new_cmd.req    = req_t'(item.req_type);
        new_cmd.guest  = guest_from_port(item.guest_reg);
        new_cmd.load   = ~item.is_dest;
        new_cmd.inv_ok = (32'(item.host_index) < 32'(NUM_SLOTS));
        new_cmd.slot   = slot_from_port(item.host_index);
    end

    assign full      = (cnt_reg == 2'(QDEPTH));
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = cmd_q_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== rtl/lfu_engine.sv =====
// lfu_engine: holds the slot table and carries out decoded commands,
// one command at a time, pushing result words into the result queue while it has room; depends on lfu_pkg
module lfu_engine import lfu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    input  logic [MASK_BITS-1:0] reserved_mask,
    input  logic                 res_full,
    output logic                 res_push,
    output lfu_out_t             res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_WB,
        ST_INV,
        ST_DONE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    cmd_t                  cur_reg;
    logic [NUM_SLOTS-1:0]  mapped_reg;
    logic [NUM_SLOTS-1:0]  mapped_next;
    logic [GUEST_BITS-1:0] slot_guest_reg [NUM_SLOTS];
    logic [USE_BITS-1:0]   slot_uses_reg  [NUM_SLOTS];

    // registered scan results
    logic                  hit_found_reg;
    logic                  hit_found_next;
    logic [SLOT_BITS-1:0]  hit_idx_reg;
    logic                  free_found_reg;
    logic                  free_found_next;
    logic [SLOT_BITS-1:0]  free_idx_reg;
    logic [NUM_GROUPS-1:0] grp_ok_reg;
    logic [NUM_GROUPS-1:0] grp_ok_next;
    logic [USE_BITS-1:0]   grp_min_reg [NUM_GROUPS];
    logic [SLOT_BITS-1:0]  grp_idx_reg [NUM_GROUPS];

    logic [NUM_SLOTS-1:0]  res_vec;
    logic [NUM_SLOTS-1:0]  hit_vec;
    logic [NUM_SLOTS-1:0]  free_vec;
    logic [NUM_SLOTS-1:0]  cand_vec;
    logic [SLOT_BITS-1:0]  hit_idx;
    logic [SLOT_BITS-1:0]  free_idx;
    logic [SLOT_BITS-1:0]  wb_idx;
    logic [USE_BITS-1:0]   grp_min [NUM_GROUPS];
    logic [SLOT_BITS-1:0]  grp_idx [NUM_GROUPS];
    logic                  vic_ok;
    logic [USE_BITS-1:0]   vic_min;
    logic [SLOT_BITS-1:0]  vic_idx;

    // control for the table update
    logic                  scan_load;
    logic                  tbl_we;
    logic [SLOT_BITS-1:0]  tbl_idx;
    logic                  bump_en;
    logic                  free_en;
    logic [SLOT_BITS-1:0]  free_sel;
    logic                  clear_all;
    logic [SLOT_BITS-1:0]  rd_idx;
    logic [GUEST_BITS-1:0] rd_guest;
    logic [SLOT_BITS-1:0]  out_slot;

    // reserved bits exist for slots below MASK_BITS only; other slots are never reserved
    for (genvar gi = 0; gi < NUM_SLOTS; gi++)
    begin : g_res
        if (gi < MASK_BITS)
        begin : g_bit
            assign res_vec[gi] = reserved_mask[gi];
        end
        else
        begin : g_none
            assign res_vec[gi] = 1'b0;
        end
    end

    // parallel compare against the head command
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            hit_vec[i]  = mapped_reg[i] && (slot_guest_reg[i] == cmd.guest);
            free_vec[i] = !mapped_reg[i] && !res_vec[i];
            cand_vec[i] = mapped_reg[i] && !res_vec[i];
        end
    end

    // lowest-index priority encoders
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        wb_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = SLOT_BITS'(i);
            end
            if (free_vec[i])
            begin
                free_idx = SLOT_BITS'(i);
            end
            if (mapped_reg[i])
            begin
                wb_idx = SLOT_BITS'(i);
            end
        end
    end

    // first level of the victim search: least count within each group
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_ok_next[g] = 1'b0;
            grp_min[g]     = '0;
            grp_idx[g]     = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if ((g * GROUP_SIZE + k) < NUM_SLOTS)
                begin
                    if (cand_vec[g * GROUP_SIZE + k] && (!grp_ok_next[g] ||
                        slot_uses_reg[g * GROUP_SIZE + k] < grp_min[g]))
                    begin
                        grp_ok_next[g] = 1'b1;
                        grp_min[g]     = slot_uses_reg[g * GROUP_SIZE + k];
                        grp_idx[g]     = SLOT_BITS'(g * GROUP_SIZE + k);
                    end
                end
            end
        end
    end

    // second level of the victim search over the group winners
    always_comb
    begin
        vic_ok  = 1'b0;
        vic_min = '0;
        vic_idx = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (grp_ok_reg[g] && (!vic_ok || grp_min_reg[g] < vic_min))
            begin
                vic_ok  = 1'b1;
                vic_min = grp_min_reg[g];
                vic_idx = grp_idx_reg[g];
            end
        end
    end

    assign hit_found_next  = |hit_vec;
    assign free_found_next = |free_vec;

    // single guest read port
    always_comb
    begin
        case (state_reg)
            ST_PICK: rd_idx = vic_idx;
            ST_WB:   rd_idx = wb_idx;
            default: rd_idx = cur_reg.slot;
        endcase
    end

    assign rd_guest = slot_guest_reg[rd_idx];

    // command sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        scan_load  = 1'b0;
        tbl_we     = 1'b0;
        tbl_idx    = free_idx_reg;
        bump_en    = 1'b0;
        free_en    = 1'b0;
        free_sel   = wb_idx;
        clear_all  = 1'b0;
        res_push   = 1'b0;
        out_slot   = '0;
        res        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.req)
                        REQ_MAP:
                        begin
                            scan_load  = 1'b1;
                            state_next = ST_PICK;
                        end
                        REQ_WB_ALL: state_next = ST_WB;
                        REQ_INVAL:  state_next = ST_INV;
                        REQ_CLEAR:
                        begin
                            clear_all  = 1'b1;
                            state_next = ST_DONE;
                        end
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PICK:
            begin
                res.last = 1'b1;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                    if (hit_found_reg)
                    begin
                        bump_en       = 1'b1;
                        out_slot      = hit_idx_reg;
                        res.kind      = KIND_HIT;
                        res.guest_out = guest_to_port(cur_reg.guest);
                    end
                    else if (free_found_reg)
                    begin
                        tbl_we          = 1'b1;
                        tbl_idx         = free_idx_reg;
                        out_slot        = free_idx_reg;
                        res.kind        = KIND_FREE;
                        res.guest_out   = guest_to_port(cur_reg.guest);
                        res.load_needed = cur_reg.load;
                    end
                    else if (vic_ok)
                    begin
                        tbl_we            = 1'b1;
                        tbl_idx           = vic_idx;
                        out_slot          = vic_idx;
                        res.kind          = KIND_EVICT;
                        res.guest_out     = guest_to_port(cur_reg.guest);
                        res.evicted_guest = guest_to_port(rd_guest);
                        res.load_needed   = cur_reg.load;
                    end
                    else
                    begin
                        res.kind = KIND_NONE;
                    end
                end
            end
            ST_WB:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (|mapped_reg)
                    begin
                        free_en       = 1'b1;
                        free_sel      = wb_idx;
                        out_slot      = wb_idx;
                        res.kind      = KIND_STORE;
                        res.guest_out = guest_to_port(rd_guest);
                    end
                    else
                    begin
                        res.kind   = KIND_DONE;
                        res.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_INV:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (cur_reg.inv_ok && mapped_reg[cur_reg.slot])
                    begin
                        free_en       = 1'b1;
                        free_sel      = cur_reg.slot;
                        out_slot      = cur_reg.slot;
                        res.kind      = KIND_STORE;
                        res.guest_out = guest_to_port(rd_guest);
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        res.kind   = KIND_DONE;
                        res.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res.kind   = KIND_DONE;
                    res.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        res.host_slot = slot_to_port(out_slot);
    end

    // mapped bits
    always_comb
    begin
        mapped_next = mapped_reg;
        if (clear_all)
        begin
            mapped_next = '0;
        end
        else if (free_en)
        begin
            mapped_next[free_sel] = 1'b0;
        end
        else if (tbl_we)
        begin
            mapped_next[tbl_idx] = 1'b1;
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mapped_reg     <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            grp_ok_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mapped_reg <= mapped_next;
            if (scan_load)
            begin
                hit_found_reg  <= hit_found_next;
                free_found_reg <= free_found_next;
                grp_ok_reg     <= grp_ok_next;
            end
        end
    end

    // command, scan payload and table contents
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (scan_load)
        begin
            hit_idx_reg  <= hit_idx;
            free_idx_reg <= free_idx;
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                grp_min_reg[g] <= grp_min[g];
                grp_idx_reg[g] <= grp_idx[g];
            end
        end
        if (tbl_we)
        begin
            slot_guest_reg[tbl_idx] <= cur_reg.guest;
            slot_uses_reg[tbl_idx]  <= USE_BITS'(1);
        end
        else if (bump_en && (slot_uses_reg[hit_idx_reg] != '1))
        begin
            slot_uses_reg[hit_idx_reg] <= slot_uses_reg[hit_idx_reg] + USE_BITS'(1);
        end
    end

    // checks
    a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result emitted into a full queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");

    a_grant_unreserved: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res.kind == KIND_FREE || res.kind == KIND_EVICT))
        |-> !res_vec[out_slot])
        else $error("reserved slot granted");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && cmd_pop && cmd.req == REQ_CLEAR)
        |=> (mapped_reg == '0))
        else $error("table not empty after clear");

endmodule

// ===== rtl/lfu_out_queue.sv =====
// lfu_out_queue: two-entry result queue between the table engine and the
// result port; depends on lfu_pkg
module lfu_out_queue import lfu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  lfu_out_t wdata,
    output logic     empty,
    input  logic     pop,
    output lfu_out_t rdata
);

    localparam int QDEPTH = 2;

    lfu_out_t   q_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'(QDEPTH));
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = q_reg[rd_ptr_reg];

    // pointer update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sim/lfu_map_checker.sv =====
// lfu_map_checker: watches the request and result words of the lfu register map
// table, keeps its own copy of the slot table and compares every popped word;
// depends on lfu_pkg
module lfu_map_checker import lfu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  lfu_in_t              item,
    input  logic                 empty,
    input  logic                 pop,
    input  lfu_out_t             result,
    input  logic                 cfg_we,
    input  logic [MASK_BITS-1:0] cfg_wdata,
    output int                   fail_count,
    output int                   open_words
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the reserved mask and the slot table
    logic [MASK_BITS-1:0]  rsv_mask;
    logic                  slot_busy  [NUM_SLOTS];
    logic [GUEST_W-1:0]    slot_reg   [NUM_SLOTS];
    logic [USE_BITS-1:0]   slot_count [NUM_SLOTS];

    // result words still owed by the table, oldest first
    lfu_out_t              owed_words [$];
    int                    errs;

    function automatic lfu_out_t make_word(input kind_t k, input int slot,
                                           input logic [GUEST_W-1:0] g,
                                           input logic [GUEST_W-1:0] ev,
                                           input logic ld, input logic lst);
        lfu_out_t w;
        w.kind          = k;
        w.host_slot     = slot[HOST_W-1:0];
        w.guest_out     = g;
        w.evicted_guest = ev;
        w.load_needed   = ld;
        w.last          = lst;
        return w;
    endfunction

    task automatic drop_slot(input int i);
        slot_busy[i]  = 1'b0;
        slot_reg[i]   = '0;
        slot_count[i] = '0;
    endtask

    // work out the words one request causes and update the table copy
    task automatic predict_request(input lfu_in_t w);
        int                 hit;
        int                 grant;
        int                 victim;
        int                 idx;
        logic               ld;
        logic [GUEST_W-1:0] old_reg;
        hit    = -1;
        grant  = -1;
        victim = -1;
        idx    = int'(w.host_index);
        ld     = !w.is_dest;
        case (req_t'(w.req_type))
            REQ_MAP:
            begin
                // hit search covers reserved slots too
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (hit < 0 && slot_busy[i] && slot_reg[i] == w.guest_reg)
                        hit = i;
                if (hit >= 0)
                begin
                    if (slot_count[hit] != '1)
                        slot_count[hit] = slot_count[hit] + 1'b1;
                    owed_words.push_back(make_word(KIND_HIT, hit, w.guest_reg, '0,
                                                   1'b0, 1'b1));
                end
                else
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (grant < 0 && !slot_busy[i] && !rsv_mask[i])
                            grant = i;
                    if (grant >= 0)
                    begin
                        slot_busy[grant]  = 1'b1;
                        slot_reg[grant]   = w.guest_reg;
                        slot_count[grant] = USE_BITS'(1);
                        owed_words.push_back(make_word(KIND_FREE, grant, w.guest_reg,
                                                       '0, ld, 1'b1));
                    end
                    else
                    begin
                        // least used unreserved slot, lowest index on ties
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (slot_busy[i] && !rsv_mask[i] &&
                                (victim < 0 || slot_count[i] < slot_count[victim]))
                                victim = i;
                        if (victim < 0)
                            owed_words.push_back(make_word(KIND_NONE, 0, '0, '0,
                                                           1'b0, 1'b1));
                        else
                        begin
                            old_reg            = slot_reg[victim];
                            slot_reg[victim]   = w.guest_reg;
                            slot_count[victim] = USE_BITS'(1);
                            owed_words.push_back(make_word(KIND_EVICT, victim,
                                                           w.guest_reg, old_reg,
                                                           ld, 1'b1));
                        end
                    end
                end
            end
            REQ_WB_ALL:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_busy[i])
                    begin
                        owed_words.push_back(make_word(KIND_STORE, i, slot_reg[i], '0,
                                                       1'b0, 1'b0));
                        drop_slot(i);
                    end
                owed_words.push_back(make_word(KIND_DONE, 0, '0, '0, 1'b0, 1'b1));
            end
            REQ_INVAL:
            begin
                if (idx < NUM_SLOTS && slot_busy[idx])
                begin
                    owed_words.push_back(make_word(KIND_STORE, idx, slot_reg[idx], '0,
                                                   1'b0, 1'b0));
                    drop_slot(idx);
                end
                owed_words.push_back(make_word(KIND_DONE, 0, '0, '0, 1'b0, 1'b1));
            end
            default:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    drop_slot(i);
                owed_words.push_back(make_word(KIND_DONE, 0, '0, '0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // compare one popped word with the oldest owed word
    task automatic check_word(input lfu_out_t got);
        lfu_out_t want;
        if (owed_words.size() == 0)
        begin
            if (errs < 10)
                $display("%0t: unexpected result word kind=%0d slot=%0d guest=%0d",
                         $realtime, got.kind, got.host_slot, got.guest_out);
            errs++;
        end
        else
        begin
            want = owed_words.pop_front();
            if (got.kind !== want.kind || got.host_slot !== want.host_slot ||
                got.guest_out !== want.guest_out ||
                got.evicted_guest !== want.evicted_guest ||
                got.load_needed !== want.load_needed || got.last !== want.last)
            begin
                if (errs < 10)
                    $display({"%0t: word mismatch expected kind=%0d slot=%0d guest=%0d ",
                              "evicted=%0d load=%0b last=%0b, got kind=%0d slot=%0d ",
                              "guest=%0d evicted=%0d load=%0b last=%0b"},
                             $realtime, want.kind, want.host_slot, want.guest_out,
                             want.evicted_guest, want.load_needed, want.last,
                             got.kind, got.host_slot, got.guest_out,
                             got.evicted_guest, got.load_needed, got.last);
                errs++;
            end
        end
    endtask

    // sample both channels and the mask port at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsv_mask = RESERVED_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
                drop_slot(i);
            owed_words.delete();
            errs = 0;
            fail_count <= 0;
            open_words <= 0;
        end
        else
        begin
            if (cfg_we)
                rsv_mask = cfg_wdata;
            if (pop && !empty)
                check_word(result);
            if (push && !full)
                predict_request(item);
            fail_count <= errs;
            open_words <= owed_words.size();
        end
    end

endmodule

// ===== sim/tb_lfu_register_map_table.sv =====
// tb_lfu_register_map_table: drives request words and pops result words of the
// lfu register map table under several idle patterns and reserved masks;
// depends on lfu_pkg, lfu_register_map_table and lfu_map_checker
module tb_lfu_register_map_table;
    import lfu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_WORDS = 45;
    localparam int HOLD_CYCLES = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    lfu_in_t              item;
    logic                 empty;
    logic                 pop;
    lfu_out_t             result;
    logic                 cfg_we;
    logic [MASK_BITS-1:0] cfg_wdata;
    int                   fail_count;
    int                   open_words;

    // idle and stall percentages, set per phase
    int                   send_idle_pct;
    int                   pop_stall_pct;
    logic                 hold_req;
    int unsigned          cycle_cnt;

    lfu_register_map_table dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lfu_map_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .open_words (open_words)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off when asked
    always
    begin
        int held;
        @(posedge clk);
        if (hold_req)
        begin
            pop  <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES)
            begin
                @(posedge clk);
                held++;
            end
            hold_req = 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end

    function automatic lfu_in_t make_req(input req_t r, input int g, input bit d,
                                         input int h);
        lfu_in_t w;
        w.req_type   = r;
        w.guest_reg  = g[GUEST_W-1:0];
        w.is_dest    = d;
        w.host_index = h[HOST_W-1:0];
        return w;
    endfunction

    // mostly maps over a small guest pool so hits and evictions are common
    function automatic lfu_in_t rand_req();
        lfu_in_t w;
        int      r;
        r            = $urandom_range(0, 99);
        w.guest_reg  = ($urandom_range(0, 3) == 0) ? GUEST_W'($urandom_range(0, 127))
                                                   : GUEST_W'($urandom_range(0, 23));
        w.is_dest    = 1'($urandom_range(0, 1));
        w.host_index = HOST_W'($urandom_range(0, 15));
        if (r < 74)
            w.req_type = REQ_MAP;
        else if (r < 88)
            w.req_type = REQ_INVAL;
        else if (r < 96)
            w.req_type = REQ_WB_ALL;
        else
            w.req_type = REQ_CLEAR;
        return w;
    endfunction

    // offer one word after a random gap, return at the edge that takes it
    task automatic send_word(input lfu_in_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full);
    endtask

    // stop offering and wait until every owed word has been popped
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (open_words != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_BITS-1:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            1:       begin send_idle_pct = 53; pop_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  pop_stall_pct = 53; end
            3:       begin send_idle_pct = 30; pop_stall_pct = 30; end
            default: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        endcase
    endtask

    // stimulus and verdict
    initial
    begin
        logic [MASK_BITS-1:0] phase_mask [6];
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        item          = '0;
        pop           = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        hold_req      = 1'b0;
        cycle_cnt     = 0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        phase_mask    = '{16'h0000, 16'hFFFF, 16'hFFFE, MASK_BITS'($urandom),
                          16'h7FFF, MASK_BITS'($urandom)};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset mask: empty table requests, grants,
        // hits, evictions, invalidates of mapped and unmapped slots
        send_word(make_req(REQ_CLEAR, 0, 1'b0, 0));
        send_word(make_req(REQ_WB_ALL, 127, 1'b1, 15));
        send_word(make_req(REQ_INVAL, 0, 1'b0, 15));
        send_word(make_req(REQ_MAP, 0, 1'b0, 0));
        send_word(make_req(REQ_MAP, 127, 1'b1, 15));
        send_word(make_req(REQ_MAP, 0, 1'b0, 0));
        send_word(make_req(REQ_MAP, 0, 1'b1, 0));
        for (int g = 1; g <= 7; g++)
            send_word(make_req(REQ_MAP, g, g[0], 0));
        send_word(make_req(REQ_MAP, 127, 1'b0, 0));
        send_word(make_req(REQ_MAP, 8, 1'b0, 0));
        send_word(make_req(REQ_MAP, 9, 1'b1, 0));
        send_word(make_req(REQ_INVAL, 0, 1'b0, 3));
        send_word(make_req(REQ_INVAL, 0, 1'b0, 0));
        send_word(make_req(REQ_WB_ALL, 0, 1'b0, 0));
        send_word(make_req(REQ_MAP, 33, 1'b0, 0));
        send_word(make_req(REQ_CLEAR, 85, 1'b1, 10));

        // random phases, one reserved mask and one idle pattern each
        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_mask(phase_mask[p]);
            set_idle(p % 4);
            if (p == 0)
            begin
                // every slot mapped, then one write back with a store per slot
                for (int g = 100; g < 116; g++)
                    send_word(make_req(REQ_MAP, g, 1'b0, 0));
                send_word(make_req(REQ_WB_ALL, 0, 1'b0, 0));
            end
            if (p == 4)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(rand_req());
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && open_words == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
